>>> hw/rtl/dxd_pkg.sv
// shared constants and codes of the distinct extrema detector
package dxd_pkg;

	localparam int MAX_SLOTS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int MAXEXT_W = 5;
	localparam int TOL_W    = 17;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 3;

	localparam logic [MAXEXT_W-1:0] MAX_EXTREMA_RST = 5'd16;
	localparam logic [TOL_W-1:0]    TOLERANCE_RST   = 17'd1;

	// register word index, taken from paddr[2]
	localparam logic REG_MAX_EXTREMA = 1'b0;
	localparam logic REG_TOLERANCE   = 1'b1;

	localparam logic [PADDR_W-1:0] ADDR_MAX_EXTREMA = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_TOLERANCE   = 3'd4;

	localparam logic KIND_EXTREMUM = 1'b0;
	localparam logic KIND_SUMMARY  = 1'b1;

endpackage

>>> hw/rtl/dxd_cell.sv
// one list cell: holds a stored extremum and tests a candidate against it
module dxd_cell #(
	parameter int SAMPLE_BITS = dxd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic signed [SAMPLE_BITS-1:0] shift_in,
	input  logic signed [SAMPLE_BITS-1:0] cand,
	input  logic [dxd_pkg::TOL_W-1:0]     tol,
	input  logic                          active,
	output logic signed [SAMPLE_BITS-1:0] held,
	output logic                          dup
);

	localparam int BW = (SAMPLE_BITS + 1 > dxd_pkg::TOL_W) ? SAMPLE_BITS + 1 : dxd_pkg::TOL_W;
	localparam int DW = BW + 1;

	logic signed [SAMPLE_BITS-1:0] value_q;
	logic signed [DW-1:0]          diff;
	logic signed [DW-1:0]          mag;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= shift_in;
		end
	end

	always_comb begin
		diff = DW'(value_q) - DW'(cand);
		mag  = (diff < 0) ? -diff : diff;
		dup  = active && ($unsigned(mag) < DW'(tol));
	end

	assign held = value_q;

endmodule

>>> hw/rtl/distinct_extrema_detector.sv
// top level of the distinct extrema detector
//
// Input channel (in_valid/in_stall) carries one signed sample per transaction
// with end_of_record on the final sample of a record. Output channel
// (out_valid/out_stall) carries result transactions: a new distinct extremum
// (kind 0) or an end-of-record summary with the final count (kind 1).
// An input sample gives zero, one or two results; is_last marks the final one.
// Results of a sample appear in the output register on the cycle after it is
// taken. One sample is taken per cycle as long as the output register is free
// or drained in the same cycle; a sample that gives two results holds the
// input while the summary waits in a second register. Stored extrema live in
// a row of cells that shift toward the far end on each new entry; all cells
// compare against the candidate in parallel. While out_stall is high the
// output holds and in_stall rises as soon as the output register is occupied.
// Reset clears the count, sample window and output valid, and loads
// max_extrema = 16, tolerance = 1.
// Configuration: APB, max_extrema at 0x0, tolerance at 0x4.
module distinct_extrema_detector #(
	parameter int MAX_SLOTS   = dxd_pkg::MAX_SLOTS_DEF,
	parameter int SAMPLE_BITS = dxd_pkg::SAMPLE_BITS_DEF,
	localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
	localparam int CNT_W      = $clog2(MAX_SLOTS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dxd_pkg::PADDR_W-1:0]     paddr,
	input  logic [dxd_pkg::PDATA_W-1:0]     pwdata,
	output logic [dxd_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            end_of_record,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kind,
	output logic signed [SAMPLE_BITS-1:0]   value,
	output logic [SLOT_W-1:0]               slot,
	output logic [CNT_W-1:0]                found_count,
	output logic                            is_last
);

	localparam int EW = (CNT_W > dxd_pkg::MAXEXT_W) ? CNT_W : dxd_pkg::MAXEXT_W;

	logic [dxd_pkg::MAXEXT_W-1:0] max_ext_q;
	logic [dxd_pkg::TOL_W-1:0]    tol_q;

	logic [CNT_W-1:0]              cnt_q;
	logic [1:0]                    seen_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] mid_q;

	logic                          out_valid_q;
	logic                          pend_q;
	logic [CNT_W-1:0]              pend_cnt_q;
	logic                          kind_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [CNT_W-1:0]              count_q;
	logic                          last_q;

	logic signed [SAMPLE_BITS-1:0] cell_val [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]          cell_dup;

	logic [EW-1:0]    eff_max;
	logic             is_ext;
	logic             search;
	logic             in_fire;
	logic             out_take;
	logic             store;
	logic [CNT_W-1:0] cnt_mid;
	logic             fallback;
	logic [CNT_W-1:0] count_fin;
	logic             first_valid;
	logic             load_out;

	logic                          kind_nxt;
	logic signed [SAMPLE_BITS-1:0] value_nxt;
	logic [SLOT_W-1:0]             slot_nxt;
	logic [CNT_W-1:0]              count_nxt;
	logic                          last_nxt;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ext_q <= dxd_pkg::MAX_EXTREMA_RST;
			tol_q     <= dxd_pkg::TOLERANCE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				dxd_pkg::REG_MAX_EXTREMA: max_ext_q <= pwdata[dxd_pkg::MAXEXT_W-1:0];
				dxd_pkg::REG_TOLERANCE:   tol_q     <= pwdata[dxd_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			dxd_pkg::ADDR_MAX_EXTREMA: prdata = dxd_pkg::PDATA_W'(max_ext_q);
			dxd_pkg::ADDR_TOLERANCE:   prdata = dxd_pkg::PDATA_W'(tol_q);
			default:                   prdata = '0;
		endcase
	end

	// cell row
	genvar gi;
	generate
		for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
			dxd_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk      (clk),
				.shift_en (store),
				.shift_in ((gi == 0) ? mid_q : cell_val[(gi == 0) ? 0 : gi - 1]),
				.cand     (mid_q),
				.tol      (tol_q),
				.active   (CNT_W'(gi) < cnt_q),
				.held     (cell_val[gi]),
				.dup      (cell_dup[gi])
			);
		end
	endgenerate

	// handshake and result selection
	assign in_stall = out_valid_q && (out_stall || pend_q);
	assign in_fire  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	always_comb begin
		eff_max = (EW'(max_ext_q) > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : EW'(max_ext_q);
		is_ext  = ((mid_q > old_q) && (sample < mid_q)) ||
		          ((mid_q < old_q) && (sample > mid_q));
		search  = (seen_q == 2'd2) && (EW'(cnt_q) < eff_max);
		store   = in_fire && search && is_ext && !(|cell_dup);
		cnt_mid = cnt_q + CNT_W'(store);
		fallback    = end_of_record && (cnt_mid == '0);
		count_fin   = fallback ? CNT_W'(1) : cnt_mid;
		first_valid = store || fallback;

		load_out  = 1'b0;
		kind_nxt  = dxd_pkg::KIND_SUMMARY;
		value_nxt = '0;
		slot_nxt  = '0;
		count_nxt = pend_cnt_q;
		last_nxt  = 1'b1;
		if (in_fire) begin
			if (first_valid) begin
				load_out  = 1'b1;
				kind_nxt  = dxd_pkg::KIND_EXTREMUM;
				value_nxt = store ? mid_q : sample;
				slot_nxt  = store ? cnt_q[SLOT_W-1:0] : '0;
				count_nxt = count_fin;
				last_nxt  = !end_of_record;
			end else if (end_of_record) begin
				load_out  = 1'b1;
				count_nxt = count_fin;
			end
		end else if (out_take && pend_q) begin
			load_out = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			seen_q      <= '0;
			old_q       <= '0;
			mid_q       <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (in_fire) begin
				if (end_of_record) begin
					cnt_q  <= '0;
					seen_q <= '0;
					old_q  <= '0;
					mid_q  <= '0;
				end else begin
					cnt_q  <= cnt_mid;
					old_q  <= mid_q;
					mid_q  <= sample;
					seen_q <= (seen_q == 2'd2) ? 2'd2 : seen_q + 2'd1;
				end
				pend_q <= first_valid && end_of_record;
			end else if (out_take) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pend_cnt_q <= count_fin;
		end
		if (load_out) begin
			kind_q  <= kind_nxt;
			value_q <= value_nxt;
			slot_q  <= slot_nxt;
			count_q <= count_nxt;
			last_q  <= last_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign slot        = slot_q;
	assign found_count = count_q;
	assign is_last     = last_q;

endmodule
